[src/ufg_pkg.sv]
// Shared types and constants for the utilization frequency governor.
// Depends on nothing; imported by the controller, datapath, top level and testbench.
`timescale 1ns / 1ps

package ufg_pkg;

   // Utilization is given in units of 1/UTIL_SCALE
   localparam int unsigned UTIL_SCALE = 1000;
   localparam int unsigned TABLE_DEPTH_DEFAULT = 32;

   // util (10 bits) * target (32 bits) gives a 42-bit dividend
   localparam int unsigned PROD_W = 42;
   localparam int unsigned DIV_STEPS = PROD_W;
   localparam int unsigned CNT_W = $clog2(DIV_STEPS + 1);

   // reference / UTIL_SCALE as (reference * UTIL_RECIP) >> UTIL_SHIFT,
   // exact for every 32-bit reference
   localparam int unsigned UTIL_SHIFT = 32 + $clog2(UTIL_SCALE);
   localparam logic [32:0] UTIL_RECIP =
      33'(((65'd1 << UTIL_SHIFT) + 65'(UTIL_SCALE - 1)) / 65'(UTIL_SCALE));

   localparam logic [31:0] RST_REFERENCE_HZ = 32'd2397000000;
   localparam logic [31:0] RST_MAX_FREQ_HZ = 32'd2397000000;
   localparam logic [31:0] RST_MIN_FREQ_HZ = 32'd0;
   localparam logic [31:0] RST_BOOST_FREQ_HZ = 32'd76800000;
   localparam logic RST_CPU_DOMAIN = 1'b1;
   localparam logic [5:0] RST_TABLE_LEN = 6'd1;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_BOOST = 2'd2,
      OP_SET = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      CSR_REFERENCE = 3'd0,
      CSR_MAX_FREQ = 3'd1,
      CSR_MIN_FREQ = 3'd2,
      CSR_BOOST_FREQ = 3'd3,
      CSR_CPU_DOMAIN = 3'd4,
      CSR_TABLE_LEN = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_SCALE,
      ST_CLAMP,
      ST_PRIME,
      ST_SRCH,
      ST_FINISH
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic div_step;
      logic mul;
      logic scale;
      logic clamp;
      logic srch_clear;
      logic srch_step;
      logic srch_take;
      logic finish;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic req_is_sample;
      logic div_last;
      logic clamp_hit;
      logic srch_end;
      logic out_free;
   } status_type;

endpackage

[src/ufg_ctrl.sv]
// Sequencing controller of the frequency governor.
// Uses ufg_pkg; drives commands to ufg_dpath and reads its status.
`timescale 1ns / 1ps

module ufg_ctrl
   import ufg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type stat,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = stat.req_is_sample ? ST_DIV : ST_FINISH;
            end
         end
         ST_DIV: begin
            if (stat.div_last) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_CLAMP;
         ST_CLAMP: state_in = stat.clamp_hit ? ST_FINISH : ST_PRIME;
         ST_PRIME: state_in = ST_SRCH;
         ST_SRCH: begin
            if (stat.srch_end) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.accept = req_valid;
         end
         ST_DIV:    cmd.div_step = 1'b1;
         ST_MUL:    cmd.mul = 1'b1;
         ST_SCALE:  cmd.scale = 1'b1;
         ST_CLAMP:  cmd.clamp = 1'b1;
         ST_PRIME:  cmd.srch_clear = 1'b1;
         ST_SRCH: begin
            cmd.srch_step = !stat.srch_end;
            cmd.srch_take = stat.srch_end;
         end
         ST_FINISH: cmd.finish = stat.out_free;
         default:   cmd = '0;
      endcase
   end

endmodule

[src/ufg_dpath.sv]
// Datapath of the frequency governor: registers, divider, multipliers,
// frequency table memory and the output register. Uses ufg_pkg.
`timescale 1ns / 1ps

module ufg_dpath
   import ufg_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  req_opcode,
   input  logic [9:0]  req_raw_util,
   input  logic [4:0]  req_entry_index,
   input  logic [31:0] req_freq_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_target_freq_hz,
   output logic        rsp_clock_set,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  cmd_type     cmd,
   output status_type  stat
);

   localparam int unsigned AW = $clog2(TABLE_DEPTH);

   // one restoring step: returns {remainder, shifted quotient}
   function automatic logic [31+PROD_W:0] div_step(input logic [31:0] rem,
                                                 input logic [PROD_W-1:0] quo,
                                                 input logic [31:0] d);
      logic [32:0] trial;
      logic        bit_q;
      logic [31:0] rem_n;
      trial = {rem, quo[PROD_W-1]};
      bit_q = (trial >= {1'b0, d});
      rem_n = bit_q ? 32'(trial - {1'b0, d}) : trial[31:0];
      return {rem_n, quo[PROD_W-2:0], bit_q};
   endfunction

   // configuration registers
   logic [31:0] ref_ff, max_ff, min_ff, boost_ff;
   logic        cpu_ff;
   logic [5:0]  len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= RST_REFERENCE_HZ;
         max_ff <= RST_MAX_FREQ_HZ;
         min_ff <= RST_MIN_FREQ_HZ;
         boost_ff <= RST_BOOST_FREQ_HZ;
         cpu_ff <= RST_CPU_DOMAIN;
         len_ff <= RST_TABLE_LEN;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_REFERENCE:  ref_ff <= csr_wdata;
            CSR_MAX_FREQ:   max_ff <= csr_wdata;
            CSR_MIN_FREQ:   min_ff <= csr_wdata;
            CSR_BOOST_FREQ: boost_ff <= csr_wdata;
            CSR_CPU_DOMAIN: cpu_ff <= csr_wdata[0];
            CSR_TABLE_LEN:  len_ff <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // item and arithmetic registers
   opcode_type          op_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [31:0]         rem_ff;
   logic [PROD_W-1:0]   quo_ff;
   logic [31:0]         refk_ff;
   logic [63:0]         prod_ff, next_ff;
   logic [31:0]         result_ff, cur_ff;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [31:0]         rd_data_ff;
   logic [31:0]         mem [TABLE_DEPTH];
   logic                rsp_valid_ff;
   logic [31:0]         rsp_target_ff;
   logic                rsp_set_ff;

   logic [31:0]         divisor;
   logic [31:0]         norm;
   logic [64:0]         ref_recip;
   logic [31:0]         boost_pick;
   logic [31:0]         eff_len;
   logic [AW-1:0]       last_idx;
   logic [31:0]         widx;
   logic                wr_ok;
   logic                ge_max, le_min, srch_hit, srch_last;
   logic                set_flag;
   logic [31+PROD_W:0]  step1;

   always_comb begin
      divisor = (ref_ff == 32'd0) ? 32'd1 : ref_ff;
      norm = (|quo_ff[PROD_W-1:32]) ? 32'hFFFF_FFFF : quo_ff[31:0];
      ref_recip = 65'(ref_ff) * 65'(UTIL_RECIP);
      boost_pick = (cpu_ff && (max_ff > boost_ff)) ? max_ff : boost_ff;
      eff_len = (len_ff == 6'd0) ? 32'd1 : 32'(len_ff);
      if (eff_len > 32'(TABLE_DEPTH)) begin
         eff_len = 32'(TABLE_DEPTH);
      end
      last_idx = AW'(eff_len - 32'd1);
      widx = 32'(req_entry_index);
      wr_ok = (widx < 32'(TABLE_DEPTH));
      ge_max = (next_ff >= {32'd0, max_ff});
      le_min = (next_ff <= {32'd0, min_ff});
      srch_hit = (next_ff <= {32'd0, rd_data_ff});
      srch_last = (idx_ff == last_idx);
      step1 = div_step(rem_ff, quo_ff, divisor);
      unique case (op_ff)
         OP_SAMPLE: set_flag = (result_ff != cur_ff) && (result_ff != 32'd0);
         OP_BOOST:  set_flag = (result_ff != 32'd0);
         OP_LOAD:   set_flag = 1'b0;
         OP_SET:    set_flag = 1'b0;
         default:   set_flag = 1'b0;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.srch_clear) begin
         idx_in = '0;
      end else if (cmd.srch_step) begin
         idx_in = idx_ff + AW'(1);
      end
   end

   // serial divider for util*target / reference; reference / UTIL_SCALE
   // is taken by reciprocal multiplication when the item is accepted
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff <= opcode_type'(req_opcode);
         cnt_ff <= CNT_W'(DIV_STEPS);
         rem_ff <= '0;
         quo_ff <= PROD_W'(req_raw_util) * PROD_W'(cur_ff);
         refk_ff <= 32'(ref_recip >> UTIL_SHIFT);
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         {rem_ff, quo_ff} <= step1;
      end
      if (cmd.mul) begin
         prod_ff <= 64'(refk_ff) * 64'(norm);
      end
      if (cmd.scale) begin
         next_ff <= prod_ff + (prod_ff >> 1);
      end
   end

   // result of the item, before it is committed
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         unique case (opcode_type'(req_opcode))
            OP_LOAD:   result_ff <= cur_ff;
            OP_BOOST:  result_ff <= boost_pick;
            OP_SET:    result_ff <= req_freq_value;
            OP_SAMPLE: result_ff <= cur_ff;
            default:   result_ff <= cur_ff;
         endcase
      end else if (cmd.clamp) begin
         // max is tested first, so it wins over an inverted min
         if (ge_max) begin
            result_ff <= max_ff;
         end else if (le_min) begin
            result_ff <= min_ff;
         end
      end else if (cmd.srch_take) begin
         // first entry at or above the value, or the last entry
         result_ff <= rd_data_ff;
      end
   end

   // frequency table; rd_data_ff tracks entry idx_ff
   always_ff @(posedge clock) begin
      if (cmd.accept && (opcode_type'(req_opcode) == OP_LOAD) && wr_ok) begin
         mem[widx[AW-1:0]] <= req_freq_value;
      end
      rd_data_ff <= mem[idx_in];
      idx_ff <= idx_in;
   end

   // committed target and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            cur_ff <= result_ff;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_target_ff <= result_ff;
         rsp_set_ff <= set_flag;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_target_freq_hz = rsp_target_ff;
   assign rsp_clock_set = rsp_set_ff;

   assign stat.req_is_sample = (opcode_type'(req_opcode) == OP_SAMPLE);
   assign stat.div_last = (cnt_ff == CNT_W'(1));
   assign stat.clamp_hit = ge_max || le_min;
   assign stat.srch_end = srch_hit || srch_last;
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

endmodule

[src/utilization_frequency_governor.sv]
// Utilization frequency governor: top level joining controller and datapath.
// Uses ufg_pkg, ufg_ctrl and ufg_dpath.
//
// Usage:
//  - req_* carries one item: load a table entry, a utilization sample, a boost
//    request or a write of the current frequency. Taken when req_valid is high
//    and req_stall low; the block holds one item at a time.
//  - rsp_* returns exactly one item per request: the target after the item and
//    whether a clock set was issued. Taken when rsp_valid high, rsp_stall low.
//  - csr_* writes a configuration register (index 0..5). Write only while the
//    block idles; the block itself does not enforce it.
// Sequence: load, boost and set go straight to the finish step. A sample runs
// the 42-step serial divider, then the multiply, scale and clamp steps; when the
// clamps do not decide, a table search stops at the first entry at or above the
// value or at the last entry. A new item is taken only once the last result has
// entered the output register.
// Reset clears the target to zero and loads register defaults; table entries
// hold nothing until loaded. While rsp_stall is high the result register holds
// and a finished item waits for it, stalling the request side.
`timescale 1ns / 1ps

module utilization_frequency_governor
   import ufg_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [9:0]  req_raw_util,
   input  logic [4:0]  req_entry_index,
   input  logic [31:0] req_freq_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_target_freq_hz,
   output logic        rsp_clock_set,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cmd_type    cmd;
   status_type stat;

   ufg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ufg_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_opcode         (req_opcode),
      .req_raw_util       (req_raw_util),
      .req_entry_index    (req_entry_index),
      .req_freq_value     (req_freq_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_target_freq_hz (rsp_target_freq_hz),
      .rsp_clock_set      (rsp_clock_set),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .cmd                (cmd),
      .stat               (stat)
   );

endmodule

[src/ufg_checker.sv]
// Port-level checks for the frequency governor, bound to the top level.
// Depends on utilization_frequency_governor.
`timescale 1ns / 1ps

module ufg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_target_freq_hz,
   input logic        rsp_clock_set
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_target_freq_hz)
                                && $stable(rsp_clock_set))
      else $error("result changed while stalled");

   // a clock set never goes out with a zero target
   a_set_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clock_set |-> rsp_target_freq_hz != 32'd0)
      else $error("clock set with zero target");

   // one item in flight: right after an accept the request side is stalled
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while busy");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind utilization_frequency_governor ufg_checker u_ufg_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_target_freq_hz (rsp_target_freq_hz),
   .rsp_clock_set      (rsp_clock_set)
);

[tb/utilization_frequency_governor_tb.sv]
// Self-checking testbench for utilization_frequency_governor.
// Directed table then random phases, checked vs typed rows or an in-bench predictor.
// Depends on ufg_pkg and the utilization_frequency_governor RTL.
`timescale 1ns / 1ps

module utilization_frequency_governor_tb;
   import ufg_pkg::*;

   localparam int TBL_DEPTH = TABLE_DEPTH_DEFAULT;
   localparam int MAX_REPORTS = 30;

   typedef struct packed {
      opcode_type  op;
      logic [9:0]  util;
      logic [4:0]  idx;
      logic [31:0] fv;
   } gov_item_type;

   typedef struct packed {
      logic [31:0] target;
      logic        set;
   } gov_result_type;

   typedef struct {
      bit             is_reg;
      csr_index_type  reg_idx;
      logic [31:0]    reg_data;
      gov_item_type   item;
      bit             typed;
      gov_result_type want;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_opcode;
   logic [9:0]  req_raw_util;
   logic [4:0]  req_entry_index;
   logic [31:0] req_freq_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_target_freq_hz;
   logic        rsp_clock_set;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   // predictor state
   logic [31:0] gov_target;
   logic [31:0] gov_table [TBL_DEPTH];
   logic [31:0] reg_reference;
   logic [31:0] reg_max;
   logic [31:0] reg_min;
   logic [31:0] reg_boost;
   logic        reg_cpu;
   logic [5:0]  reg_len;

   gov_result_type expected_targets [$];
   int             mismatches;
   bit             sender_calm;
   bit             hold_go;
   logic           hold_on;
   int             stall_left;
   int             calm_left;
   dir_row_type    rows [$];

   utilization_frequency_governor DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_raw_util       (req_raw_util),
      .req_entry_index    (req_entry_index),
      .req_freq_value     (req_freq_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_target_freq_hz (rsp_target_freq_hz),
      .rsp_clock_set      (rsp_clock_set),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      #20000000;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < MAX_REPORTS)
         $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // Next target for one item; updates the predictor state.
   function automatic gov_result_type advance_governor(input gov_item_type it);
      logic [31:0] prev;
      logic [63:0] divisor;
      logic [63:0] norm;
      logic [63:0] want;
      logic        set;
      int          n;
      bit          hit;
      prev = gov_target;
      set = 1'b0;
      case (it.op)
         OP_LOAD: begin
            gov_table[it.idx] = it.fv;
         end
         OP_SAMPLE: begin
            divisor = (reg_reference == 32'd0) ? 64'd1 : 64'(reg_reference);
            norm = (64'(it.util) * 64'(gov_target)) / divisor;
            if (norm > 64'hFFFF_FFFF)
               norm = 64'hFFFF_FFFF;
            want = (64'(reg_reference) / 64'(UTIL_SCALE)) * norm;
            want = want + (want >> 1);
            if (want >= 64'(reg_max)) begin
               gov_target = reg_max;
            end else if (want <= 64'(reg_min)) begin
               gov_target = reg_min;
            end else begin
               // zero length acts as one entry, oversize as the full table
               n = (reg_len == 6'd0) ? 1 : ((reg_len > TBL_DEPTH) ? TBL_DEPTH : int'(reg_len));
               gov_target = gov_table[n - 1];
               hit = 1'b0;
               for (int i = 0; i < n; i++) begin
                  if (!hit && want <= 64'(gov_table[i])) begin
                     gov_target = gov_table[i];
                     hit = 1'b1;
                  end
               end
            end
            set = (gov_target != prev) && (gov_target != 32'd0);
         end
         OP_BOOST: begin
            gov_target = reg_boost;
            if (reg_cpu && reg_max > reg_boost)
               gov_target = reg_max;
            set = gov_target != 32'd0;
         end
         default: begin
            gov_target = it.fv;
         end
      endcase
      return '{gov_target, set};
   endfunction

   // Register write, only with nothing in flight.
   task automatic write_reg(input csr_index_type idx, input logic [31:0] data);
      if (req_valid)
         req_valid <= 1'b0;
      while (expected_targets.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_REFERENCE:  reg_reference = data;
         CSR_MAX_FREQ:   reg_max = data;
         CSR_MIN_FREQ:   reg_min = data;
         CSR_BOOST_FREQ: reg_boost = data;
         CSR_CPU_DOMAIN: reg_cpu = data[0];
         CSR_TABLE_LEN:  reg_len = data[5:0];
         default: ;
      endcase
      csr_wr_en <= 1'b0;
   endtask

   task automatic offer_item(input gov_item_type it, input bit typed,
                             input gov_result_type want);
      int r;
      int g;
      req_valid <= 1'b1;
      req_opcode <= it.op;
      req_raw_util <= it.util;
      req_entry_index <= it.idx;
      req_freq_value <= it.fv;
      do @(posedge clock); while (req_stall);
      if (typed) begin
         void'(advance_governor(it));
         expected_targets.push_back(want);
      end else begin
         expected_targets.push_back(advance_governor(it));
      end
      r = $urandom_range(0, 99);
      if (sender_calm || r < 55)
         g = 0;
      else if (r < 88)
         g = $urandom_range(1, 3);
      else if (r < 97)
         g = $urandom_range(4, 12);
      else
         g = $urandom_range(20, 60);
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   function automatic dir_row_type reg_row(input csr_index_type idx, input logic [31:0] data);
      dir_row_type row;
      row = '{reg_idx: CSR_REFERENCE, default: '0};
      row.is_reg = 1'b1;
      row.reg_idx = idx;
      row.reg_data = data;
      return row;
   endfunction

   function automatic dir_row_type item_row(input opcode_type op, input logic [9:0] util,
                                            input logic [4:0] idx, input logic [31:0] fv,
                                            input bit typed, input logic [31:0] target,
                                            input logic set);
      dir_row_type row;
      row = '{reg_idx: CSR_REFERENCE, default: '0};
      row.item = '{op, util, idx, fv};
      row.typed = typed;
      row.want = '{target, set};
      return row;
   endfunction

   // Response checker and receiver-side stall.
   always @(posedge clock) begin
      gov_result_type exp_res;
      int             r;
      logic           stall_now;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_targets.size() == 0) begin
               report_mismatch("result with no item pending", rsp_target_freq_hz, 32'd0);
            end else begin
               exp_res = expected_targets.pop_front();
               if (rsp_target_freq_hz !== exp_res.target)
                  report_mismatch("target_freq_hz", rsp_target_freq_hz, exp_res.target);
               if (rsp_clock_set !== exp_res.set)
                  report_mismatch("clock_set", 32'(rsp_clock_set), 32'(exp_res.set));
            end
         end
         stall_now = 1'b0;
         if (hold_on) begin
            stall_now = 1'b1;
         end else if (stall_left > 0) begin
            stall_now = 1'b1;
            stall_left--;
         end else if (calm_left > 0) begin
            calm_left--;
         end else begin
            r = $urandom_range(0, 999);
            if (r < 5) begin
               calm_left = $urandom_range(150, 400);
            end else if (r < 15) begin
               stall_now = 1'b1;
               stall_left = $urandom_range(30, 80);
            end else if (r < 200) begin
               stall_now = 1'b1;
               stall_left = $urandom_range(0, 2);
            end
         end
         rsp_stall <= stall_now;
      end
   end

   // Long receiver hold-off so the block fills and stalls its input.
   initial begin
      hold_on = 1'b0;
      wait (hold_go);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (600) @(posedge clock);
      hold_on <= 1'b0;
   end

   initial begin
      gov_item_type it;
      logic [31:0]  ph_ref;
      logic [31:0]  ph_max;
      logic [31:0]  ph_min;
      logic [31:0]  ph_boost;
      logic         ph_cpu;
      logic [5:0]   ph_len;
      logic [31:0]  junk;
      logic [63:0]  lo;
      logic [63:0]  span;
      int           r;

      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_LOAD;
      req_raw_util = '0;
      req_entry_index = '0;
      req_freq_value = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_REFERENCE;
      csr_wdata = '0;
      mismatches = 0;
      sender_calm = 1'b0;
      hold_go = 1'b0;
      stall_left = 0;
      calm_left = 0;
      gov_target = '0;
      for (int i = 0; i < TBL_DEPTH; i++)
         gov_table[i] = '0;
      reg_reference = RST_REFERENCE_HZ;
      reg_max = RST_MAX_FREQ_HZ;
      reg_min = RST_MIN_FREQ_HZ;
      reg_boost = RST_BOOST_FREQ_HZ;
      reg_cpu = RST_CPU_DOMAIN;
      reg_len = RST_TABLE_LEN;

      // directed: reset state, extremes, boost rules, clamp order, odd registers
      rows.push_back(item_row(OP_SAMPLE, 10'd1000, 5'd0, 32'd0, 1, 32'd0, 1'b0));
      rows.push_back(item_row(OP_SAMPLE, 10'd0, 5'd0, 32'd0, 1, 32'd0, 1'b0));
      rows.push_back(item_row(OP_BOOST, 10'd0, 5'd0, 32'd0, 1, 32'd2397000000, 1'b1));
      rows.push_back(item_row(OP_LOAD, 10'd0, 5'd0, 32'd1200000000, 1, 32'd2397000000, 1'b0));
      rows.push_back(item_row(OP_LOAD, 10'd0, 5'd31, 32'hFFFF_FFFF, 1, 32'd2397000000, 1'b0));
      rows.push_back(item_row(OP_SAMPLE, 10'd1000, 5'd0, 32'd0, 0, 32'd0, 1'b0));
      rows.push_back(item_row(OP_SET, 10'd0, 5'd0, 32'd1000000000, 1, 32'd1000000000, 1'b0));
      rows.push_back(item_row(OP_SAMPLE, 10'd1000, 5'd0, 32'd0, 0, 32'd0, 1'b0));
      rows.push_back(item_row(OP_SAMPLE, 10'd1023, 5'd0, 32'd0, 0, 32'd0, 1'b0));
      rows.push_back(item_row(OP_SET, 10'd0, 5'd0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1'b0));
      rows.push_back(item_row(OP_SAMPLE, 10'd1023, 5'd0, 32'd0, 0, 32'd0, 1'b0));
      rows.push_back(item_row(OP_SET, 10'd0, 5'd0, 32'd0, 1, 32'd0, 1'b0));
      rows.push_back(reg_row(CSR_CPU_DOMAIN, 32'd0));
      rows.push_back(item_row(OP_BOOST, 10'd0, 5'd0, 32'd0, 1, 32'd76800000, 1'b1));
      rows.push_back(reg_row(CSR_BOOST_FREQ, 32'd0));
      rows.push_back(item_row(OP_BOOST, 10'd0, 5'd0, 32'd0, 1, 32'd0, 1'b0));
      rows.push_back(reg_row(CSR_CPU_DOMAIN, 32'd1));
      rows.push_back(item_row(OP_BOOST, 10'd0, 5'd0, 32'd0, 1, 32'd2397000000, 1'b1));
      rows.push_back(reg_row(CSR_MIN_FREQ, 32'hFFFF_FFFF));
      rows.push_back(item_row(OP_SET, 10'd0, 5'd0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1'b0));
      rows.push_back(item_row(OP_SAMPLE, 10'd1023, 5'd0, 32'd0, 0, 32'd0, 1'b0));
      rows.push_back(item_row(OP_SAMPLE, 10'd0, 5'd0, 32'd0, 0, 32'd0, 1'b0));
      rows.push_back(reg_row(CSR_MIN_FREQ, 32'd0));
      rows.push_back(reg_row(CSR_MAX_FREQ, 32'hFFFF_FFFF));
      rows.push_back(reg_row(CSR_TABLE_LEN, 32'd0));
      rows.push_back(item_row(OP_SET, 10'd0, 5'd0, 32'd3000000000, 1, 32'd3000000000, 1'b0));
      rows.push_back(item_row(OP_SAMPLE, 10'd700, 5'd0, 32'd0, 0, 32'd0, 1'b0));
      rows.push_back(reg_row(CSR_REFERENCE, 32'd0));
      rows.push_back(item_row(OP_SAMPLE, 10'd1000, 5'd0, 32'd0, 0, 32'd0, 1'b0));
      rows.push_back(reg_row(CSR_REFERENCE, 32'd999));
      rows.push_back(item_row(OP_SET, 10'd0, 5'd0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1'b0));
      rows.push_back(item_row(OP_SAMPLE, 10'd1023, 5'd0, 32'd0, 0, 32'd0, 1'b0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].is_reg)
            write_reg(rows[i].reg_idx, rows[i].reg_data);
         else
            offer_item(rows[i].item, rows[i].typed, rows[i].want);
      end

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin
               ph_ref = 32'd2397000000;
               ph_max = 32'd2397000000;
               ph_min = 32'd0;
               ph_boost = 32'd76800000;
               ph_cpu = 1'b1;
               ph_len = 6'd32;
            end
            1: begin
               ph_ref = 32'hFFFF_FFFF;
               ph_max = 32'hFFFF_FFFF;
               ph_min = 32'd0;
               ph_boost = 32'hFFFF_FFFF;
               ph_cpu = 1'b0;
               ph_len = 6'd63;
            end
            2: begin
               // small numbers: reference over UTIL_SCALE is one
               ph_ref = 32'd1000;
               ph_max = 32'd3000;
               ph_min = 32'd10;
               ph_boost = 32'd0;
               ph_cpu = 1'b1;
               ph_len = 6'd0;
            end
            3: begin
               // zero reference, min above a zero max
               ph_ref = 32'd0;
               ph_max = 32'd0;
               ph_min = 32'hFFFF_FFFF;
               ph_boost = $urandom;
               ph_cpu = 1'b1;
               ph_len = 6'd1;
            end
            default: begin
               ph_ref = $urandom_range(1000000, 32'hFFFF_FFFF);
               ph_max = $urandom_range(100000000, 32'hFFFF_FFFF);
               ph_min = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, ph_max / 2);
               ph_boost = $urandom;
               ph_cpu = $urandom_range(0, 1);
               ph_len = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                                    : 6'($urandom_range(1, 32));
            end
         endcase
         junk = (p >= 5) ? $urandom : 32'd0;
         write_reg(CSR_REFERENCE, ph_ref);
         write_reg(CSR_MAX_FREQ, ph_max);
         write_reg(CSR_MIN_FREQ, ph_min);
         write_reg(CSR_BOOST_FREQ, ph_boost);
         write_reg(CSR_CPU_DOMAIN, (junk & ~32'h1) | 32'(ph_cpu));
         write_reg(CSR_TABLE_LEN, (junk & ~32'h3F) | 32'(ph_len));
         sender_calm = (p == 2) || (p == 4) || (p == 5);

         // ascending table spread between the clamps; one phase gets a scrambled one
         lo = (ph_min <= ph_max) ? 64'(ph_min) : 64'(ph_max);
         span = (ph_min <= ph_max) ? 64'(ph_max - ph_min) : 64'(ph_min - ph_max);
         for (int i = 0; i < TBL_DEPTH; i++) begin
            it = '{OP_LOAD, 10'($urandom), 5'(i), 32'(lo + span * 64'(i + 1) / 64'd33)};
            if (p == 6)
               it.fv = $urandom;
            offer_item(it, 0, '0);
         end

         if (p == 4)
            hold_go = 1'b1;

         repeat (170) begin
            it = '{opcode_type'($urandom_range(0, 3)), 10'($urandom), 5'($urandom), $urandom};
            r = $urandom_range(0, 99);
            if (r < 25) begin
               it.op = OP_LOAD;
               if ($urandom_range(0, 9) < 7)
                  it.fv = gov_table[it.idx] ^ 32'($urandom_range(0, 255));
            end else if (r < 70) begin
               it.op = OP_SAMPLE;
               r = $urandom_range(0, 9);
               if (r == 0)
                  it.util = 10'd0;
               else if (r == 1)
                  it.util = 10'd1000;
               else if (r == 2)
                  it.util = 10'($urandom_range(1001, 1023));
               else
                  it.util = 10'($urandom_range(0, 1000));
            end else if (r < 80) begin
               it.op = OP_BOOST;
            end else begin
               it.op = OP_SET;
               r = $urandom_range(0, 19);
               if (r < 10)
                  it.fv = 32'(lo + ((span * 64'($urandom_range(0, 1000))) / 64'd1000));
               else if (r < 14)
                  it.fv = gov_table[$urandom_range(0, TBL_DEPTH - 1)];
               else if (r < 17)
                  it.fv = $urandom;
               else if (r < 19)
                  it.fv = 32'd0;
               else
                  it.fv = 32'hFFFF_FFFF;
            end
            offer_item(it, 0, '0);
         end
      end

      if (req_valid)
         req_valid <= 1'b0;
      while (expected_targets.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
